// File: rtl/unsharp_mask_3x3_rgb_macros.svh
// Assertion macros shared by the unsharp mask RTL.
`ifndef UNSHARP_MASK_3X3_RGB_MACROS_SVH
`define UNSHARP_MASK_3X3_RGB_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ums_pkg.sv
// Shared types, constants and the blur kernel of the unsharp mask block.
`timescale 1ns / 1ps
package ums_pkg;

  localparam int MaxWidthDef  = 2048;
  localparam int MaxHeightDef = 2048;

  localparam logic [11:0] ResetWidth     = 12'd1920;
  localparam logic [11:0] ResetHeight    = 12'd1080;
  localparam logic [7:0]  ResetThreshold = 8'd3;
  localparam logic [7:0]  ResetAmount    = 8'd32;

  localparam logic [7:0] WeightCorner = 8'd19;
  localparam logic [7:0] WeightEdge   = 8'd32;
  localparam logic [7:0] WeightCenter = 8'd52;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2,
    REG_AMOUNT       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Nine pixels, row major, center at index 4.
  typedef rgb_t [8:0] patch_t;

  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } column_t;

  typedef struct packed {
    logic p0;
    logic p1;
    logic c_is0;
    logic c_is1;
    logic tclamp;
    logic row_end;
  } win_ctl_t;

  typedef struct packed {
    rgb_t blur;
    rgb_t center;
    logic run_last;
    logic frame_end;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } s2_load_t;

  function automatic logic [7:0] kernel_weight(input logic [3:0] idx);
    logic [7:0] wt;
    case (idx)
      4'd4:                         wt = WeightCenter;
      4'd1, 4'd3, 4'd5, 4'd7:       wt = WeightEdge;
      default:                      wt = WeightCorner;
    endcase
    return wt;
  endfunction

  // Weighted sum over the patch, floor divided by 256.
  function automatic rgb_t kernel_blur(input patch_t p);
    logic [15:0] sr;
    logic [15:0] sg;
    logic [15:0] sb;
    rgb_t        res;
    sr = '0;
    sg = '0;
    sb = '0;
    for (int i = 0; i < 9; i++) begin
      sr = sr + 16'(p[i].red)   * 16'(kernel_weight(4'(i)));
      sg = sg + 16'(p[i].green) * 16'(kernel_weight(4'(i)));
      sb = sb + 16'(p[i].blue)  * 16'(kernel_weight(4'(i)));
    end
    res.red   = sr[15:8];
    res.green = sg[15:8];
    res.blue  = sb[15:8];
    return res;
  endfunction

endpackage

// File: rtl/ums_line_buf.sv
// Two line rows of packed RGB: one write port, one registered read port.
`timescale 1ns / 1ps
module ums_line_buf #(
  parameter int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  ums_pkg::rgb_t     wr_top_i,
  input  ums_pkg::rgb_t     wr_mid_i,
  output ums_pkg::rgb_t     rd_top_o,
  output ums_pkg::rgb_t     rd_mid_o
);
  import ums_pkg::*;

  rgb_t top_mem [Depth];
  rgb_t mid_mem [Depth];
  rgb_t rd_top_q;
  rgb_t rd_mid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      top_mem[wr_addr_i] <= wr_top_i;
      mid_mem[wr_addr_i] <= wr_mid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_top_q <= top_mem[rd_addr_i];
      rd_mid_q <= mid_mem[rd_addr_i];
    end
  end

  assign rd_top_o = rd_top_q;
  assign rd_mid_o = rd_mid_q;

endmodule

// File: rtl/ums_window.sv
// 3x3 pixel window with the blur of the one or two patches a pixel completes.
`timescale 1ns / 1ps
module ums_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  ums_pkg::column_t    col_i,
  input  ums_pkg::win_ctl_t   ctl_i,
  output ums_pkg::s2_load_t   load_o
);
  import ums_pkg::*;

  rgb_t [2:0][2:0] win_q;
  rgb_t [2:0][2:0] win_d;
  patch_t          p0;
  patch_t          p1;
  logic [1:0]      src;
  logic [1:0]      l0;
  logic [1:0]      l1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = col_i.top;
    win_d[1][2] = col_i.mid;
    win_d[2][2] = col_i.bot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  // On the first output row the top row repeats the middle one; at the
  // left edge the left column repeats the center one.
  always_comb begin
    l0 = ctl_i.c_is1 ? 2'd1 : 2'd0;
    l1 = ctl_i.c_is0 ? 2'd2 : 2'd1;
    src = 2'd0;
    for (int r = 0; r < 3; r++) begin
      src = (r == 0 && ctl_i.tclamp) ? 2'd1 : 2'(r);
      p0[r*3 + 0] = win_d[src][l0];
      p0[r*3 + 1] = win_d[src][1];
      p0[r*3 + 2] = win_d[src][2];
      p1[r*3 + 0] = win_d[src][l1];
      p1[r*3 + 1] = win_d[src][2];
      p1[r*3 + 2] = win_d[src][2];
    end
  end

  always_comb begin
    load_o.v0           = ctl_i.p0;
    load_o.v1           = ctl_i.p1;
    load_o.r0.blur      = kernel_blur(p0);
    load_o.r0.center    = win_d[1][1];
    load_o.r0.run_last  = !ctl_i.row_end;
    load_o.r0.frame_end = 1'b0;
    load_o.r1.blur      = kernel_blur(p1);
    load_o.r1.center    = win_d[1][2];
    load_o.r1.run_last  = 1'b1;
    load_o.r1.frame_end = 1'b0;
  end

endmodule

// File: rtl/ums_out.sv
// Result slots, sharpening arithmetic and the output register.
`timescale 1ns / 1ps
module ums_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         threshold_i,
  input  logic [7:0]         amount_i,
  input  logic               load_en_i,
  input  ums_pkg::s2_load_t  load_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               run_last_o,
  output logic               frame_end_o
);
  import ums_pkg::*;

  logic v0_q, v1_q;
  res_t r0_q, r1_q;
  res_t sel;
  logic out_free, send;
  logic out_valid_q;
  rgb_t out_pix_q;
  logic run_last_q, frame_end_q;

  function automatic logic [7:0] sharpen(input logic [7:0] blur, input logic [7:0] img,
                                         input logic [7:0] amt, input logic [7:0] thr);
    logic        neg;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [11:0] m;
    logic [12:0] sum;
    logic [7:0]  res;
    neg  = img < blur;
    mag  = neg ? (blur - img) : (img - blur);
    prod = 16'(mag) * 16'(amt);
    m    = prod[15:4];
    sum  = 13'(img) + 13'(m);
    if (m <= 12'(thr)) begin
      res = img;
    end else if (neg) begin
      res = (12'(img) > m) ? 8'(12'(img) - m) : 8'd0;
    end else begin
      res = (sum > 13'd255) ? 8'd255 : sum[7:0];
    end
    return res;
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign send     = (v0_q || v1_q) && out_free;
  assign sel      = v0_q ? r0_q : r1_q;
  assign free_o   = !(v0_q || v1_q) || (out_free && !(v0_q && v1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (load_en_i) begin
      v0_q <= load_i.v0;
      v1_q <= load_i.v1;
    end else if (send) begin
      if (v0_q) begin
        v0_q <= 1'b0;
      end else begin
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      r0_q <= load_i.r0;
      r1_q <= load_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (send) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send) begin
      out_pix_q.red   <= sharpen(sel.blur.red,   sel.center.red,   amount_i, threshold_i);
      out_pix_q.green <= sharpen(sel.blur.green, sel.center.green, amount_i, threshold_i);
      out_pix_q.blue  <= sharpen(sel.blur.blue,  sel.center.blue,  amount_i, threshold_i);
      run_last_q      <= sel.run_last;
      frame_end_q     <= sel.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q.red;
  assign out_green_o = out_pix_q.green;
  assign out_blue_o  = out_pix_q.blue;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

// File: rtl/unsharp_mask_3x3_rgb.sv
// Top level of the streaming 3x3 unsharp mask on RGB pixels.
`timescale 1ns / 1ps
// Pixels enter in raster order, one transaction per clock while in_ready_o
// is high, and each one is blurred with the 3x3 Gaussian kernel
// (19, 32, 52) / 256 with clamp-to-edge borders and then sharpened by
// amount_sixteenths / 16 wherever the difference scaled by that amount
// exceeds sharpen_threshold. Output (r, c) appears after input (r+1, c+1)
// has been taken, so results lag one row plus one pixel; the last pixel of
// every row after the first produces two results, which the output side
// hands over one after the other, so the input stalls there. The final row
// is released by drain transactions (action = 1), one pixel each; a drain
// transaction holds the input stage while its three columns are fetched one
// after another through the single read port of the line buffer. A drain
// with nothing pending is taken and yields nothing. A pixel transaction is
// held in an input stage while its line buffer read returns, the window and
// blur logic then loads a result slot stage, and the sharpening logic loads
// the output register, which then holds the result valid at the output. The
// line buffer needs no clearing after reset; entries that were never written
// are only read where edge clamping throws them away. Configuration should be
// written only while no transaction is in flight.
module unsharp_mask_3x3_rgb #(
  parameter int MAX_WIDTH  = ums_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = ums_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        run_last_o,
  output logic        frame_end_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i
);
  import ums_pkg::*;

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Drain fetch phases: left column, center column, right column.
  localparam logic [1:0] PH_L = 2'd0;
  localparam logic [1:0] PH_D = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  // Configuration registers.
  logic [11:0] img_w_q, img_h_q;
  logic [7:0]  thr_q, amt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= ResetWidth;
      img_h_q <= ResetHeight;
      thr_q   <= ResetThreshold;
      amt_q   <= ResetAmount;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i;
        REG_THRESHOLD:    thr_q   <= cfg_wdata_i[7:0];
        REG_AMOUNT:       amt_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective size minus one: zero counts as one, oversize as the maximum.
  logic [13:0]     w_ext, h_ext;
  logic [ColW-1:0] w_m1;
  logic [RowW-1:0] h_m1;

  assign w_ext = {2'b00, img_w_q};
  assign h_ext = {2'b00, img_h_q};

  always_comb begin
    if (w_ext == '0) begin
      w_m1 = '0;
    end else if (w_ext > 14'(MAX_WIDTH)) begin
      w_m1 = ColW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = ColW'(w_ext - 14'd1);
    end
    if (h_ext == '0) begin
      h_m1 = '0;
    end else if (h_ext > 14'(MAX_HEIGHT)) begin
      h_m1 = RowW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RowW'(h_ext - 14'd1);
    end
  end

  // Raster position and drain bookkeeping.
  logic [ColW-1:0] in_col_q, in_col_d, drn_col_q, drn_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic            drn_pend_q, drn_pend_d;
  logic [ColW-1:0] c_cur, d_cur, l_cur, r_cur;
  logic            row_end, frame_done, d_fend;
  logic            in_acc, take_item;

  assign c_cur      = (in_col_q > w_m1) ? w_m1 : in_col_q;
  assign row_end    = (c_cur == w_m1);
  assign frame_done = (in_row_q >= h_m1);
  assign d_cur      = (drn_col_q > w_m1) ? w_m1 : drn_col_q;
  assign l_cur      = (d_cur != '0) ? (d_cur - ColW'(1)) : d_cur;
  assign r_cur      = (d_cur < w_m1) ? (d_cur + ColW'(1)) : d_cur;
  assign d_fend     = (d_cur == w_m1);

  assign in_acc    = in_valid_i && in_ready_o;
  // A drain transaction with nothing pending is taken and yields nothing.
  assign take_item = in_acc && (!action_i || drn_pend_q);

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    drn_col_d  = drn_col_q;
    drn_pend_d = drn_pend_q;
    if (in_acc) begin
      if (action_i) begin
        if (drn_pend_q) begin
          if (d_fend) begin
            drn_pend_d = 1'b0;
            drn_col_d  = '0;
          end else begin
            drn_col_d = d_cur + ColW'(1);
          end
        end
      end else begin
        // A pixel drops any drains still pending and starts a new frame.
        drn_pend_d = 1'b0;
        drn_col_d  = '0;
        if (row_end) begin
          in_col_d = '0;
          if (frame_done) begin
            in_row_d   = '0;
            drn_pend_d = 1'b1;
          end else begin
            in_row_d = in_row_q + RowW'(1);
          end
        end else begin
          in_col_d = c_cur + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      drn_col_q  <= '0;
      drn_pend_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      drn_col_q  <= drn_col_d;
      drn_pend_q <= drn_pend_d;
    end
  end

  // Input stage: holds the transaction while the line buffer read returns.
  logic            s1_valid_q, s1_drain_q, s1_adv;
  logic [1:0]      s1_phase_q;
  rgb_t            s1_pix_q;
  logic [ColW-1:0] s1_col_q, s1_dcol_q, s1_rcol_q;
  win_ctl_t        s1_ctl_q;
  logic            s1_fend_q, s1_tall_q;
  logic            s2_free;

  assign s1_adv     = s1_valid_q && (!s1_drain_q || s1_phase_q == PH_R) && s2_free;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_drain_q <= 1'b0;
      s1_phase_q <= PH_L;
    end else if (take_item) begin
      s1_valid_q <= 1'b1;
      s1_drain_q <= action_i;
      s1_phase_q <= PH_L;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_drain_q) begin
        unique case (s1_phase_q)
          PH_L:    s1_phase_q <= PH_D;
          PH_D:    s1_phase_q <= PH_R;
          PH_R:    s1_phase_q <= PH_R;
          default: s1_phase_q <= PH_R;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_item) begin
      s1_pix_q         <= '{red: in_red_i, green: in_green_i, blue: in_blue_i};
      s1_col_q         <= c_cur;
      s1_dcol_q        <= d_cur;
      s1_rcol_q        <= r_cur;
      s1_fend_q        <= d_fend;
      s1_tall_q        <= (h_m1 != '0);
      s1_ctl_q.p0      <= (in_row_q != '0) && (c_cur != '0);
      s1_ctl_q.p1      <= (in_row_q != '0) && row_end;
      s1_ctl_q.c_is0   <= (c_cur == '0);
      s1_ctl_q.c_is1   <= (c_cur == ColW'(1));
      s1_ctl_q.tclamp  <= (in_row_q == RowW'(1));
      s1_ctl_q.row_end <= row_end;
    end
  end

  // Line buffer access with forwarding of a write to the same column.
  logic            rd_en, wr_en, fwd_q;
  logic [ColW-1:0] rd_addr;
  rgb_t            ram_top, ram_mid, fwd_top_q, fwd_mid_q, col_top, col_mid;

  assign rd_en   = take_item ||
                   (s1_valid_q && s1_drain_q && (s1_phase_q == PH_L || s1_phase_q == PH_D));
  assign rd_addr = take_item ? (action_i ? l_cur : c_cur) :
                   ((s1_phase_q == PH_L) ? s1_dcol_q : s1_rcol_q);
  assign wr_en   = s1_adv && !s1_drain_q;
  assign col_top = fwd_q ? fwd_top_q : ram_top;
  assign col_mid = fwd_q ? fwd_mid_q : ram_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en) begin
      fwd_q <= wr_en && (rd_addr == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      fwd_top_q <= col_mid;
      fwd_mid_q <= s1_pix_q;
    end
  end

  ums_line_buf #(
    .Depth (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_col_q),
    .wr_top_i  (col_mid),
    .wr_mid_i  (s1_pix_q),
    .rd_top_o  (ram_top),
    .rd_mid_o  (ram_mid)
  );

  // Pixel path: window shift and blur of the completed patches.
  column_t  win_col;
  s2_load_t win_load;

  assign win_col = '{top: col_top, mid: col_mid, bot: s1_pix_q};

  ums_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (wr_en),
    .col_i   (win_col),
    .ctl_i   (s1_ctl_q),
    .load_o  (win_load)
  );

  // Drain path: the left and center columns are captured in turn while the
  // next column is being read.
  rgb_t     dl_top_q, dl_mid_q, dd_top_q, dd_mid_q;
  patch_t   dp;
  s2_load_t drn_load, s2_load;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_drain_q && s1_phase_q == PH_L) begin
      dl_top_q <= col_top;
      dl_mid_q <= col_mid;
    end
    if (s1_valid_q && s1_drain_q && s1_phase_q == PH_D) begin
      dd_top_q <= col_top;
      dd_mid_q <= col_mid;
    end
  end

  always_comb begin
    // A one-row frame uses the last row for the top of the patch too.
    dp[0] = s1_tall_q ? dl_top_q : dl_mid_q;
    dp[1] = s1_tall_q ? dd_top_q : dd_mid_q;
    dp[2] = s1_tall_q ? col_top : col_mid;
    dp[3] = dl_mid_q;
    dp[4] = dd_mid_q;
    dp[5] = col_mid;
    dp[6] = dl_mid_q;
    dp[7] = dd_mid_q;
    dp[8] = col_mid;
    drn_load.v0           = 1'b1;
    drn_load.v1           = 1'b0;
    drn_load.r0.blur      = kernel_blur(dp);
    drn_load.r0.center    = dd_mid_q;
    drn_load.r0.run_last  = 1'b1;
    drn_load.r0.frame_end = s1_fend_q;
    drn_load.r1           = '0;
  end

  assign s2_load = s1_drain_q ? drn_load : win_load;

  ums_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .amount_i    (amt_q),
    .load_en_i   (s1_adv),
    .load_i      (s2_load),
    .free_o      (s2_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

`include "unsharp_mask_3x3_rgb_macros.svh"

  `UMS_ASSERT_SAME(a_drain_fetch_blocks_input, s1_valid_q && s1_drain_q && s1_phase_q != PH_R, !in_ready_o, "input taken during drain column fetch")
  `UMS_ASSERT_NEXT(a_drain_starts_fetch, in_acc && action_i && drn_pend_q, s1_valid_q && s1_drain_q && s1_phase_q == PH_L, "pending drain did not start its fetch")
  `UMS_ASSERT_SAME(a_pending_at_origin, drn_pend_q, in_col_q == '0 && in_row_q == '0, "drain pending away from frame origin")

endmodule
